/* src/flwh_pkg.sv */
// ----------------------------------------------------------------------------
// flwh_pkg
// Shared constants, types and the lane absorb function of the four-lane
// word hash.
// ----------------------------------------------------------------------------
`default_nettype none

package flwh_pkg;

    localparam int WORD_W  = 64;
    localparam int LANES   = 4;
    localparam int COUNT_W = 3;

    localparam logic [WORD_W-1:0] SEED_ONE   = 64'h243f6a8885a308d3;
    localparam logic [WORD_W-1:0] SEED_TWO   = 64'h13198a2e03707344;
    localparam logic [WORD_W-1:0] SEED_THREE = 64'ha4093822299f31d0;
    localparam logic [WORD_W-1:0] SEED_FOUR  = 64'h082efa98ec4e6c89;

    // FNV-64 prime is 2^40 + 0x1b3: a shift plus a narrow constant multiply
    localparam int               PRIME_SHIFT = 40;
    localparam logic [WORD_W-1:0] PRIME_LOW  = 64'h1b3;

    localparam logic [WORD_W-1:0] MIX_ADD   = 64'h9e3779b97f4a7c15;
    localparam int               MIX_LEFT  = 17;
    localparam int               MIX_RIGHT = 13;

    typedef logic [LANES-1:0][WORD_W-1:0] lane_vec_t;

    typedef struct packed {
        logic absorb;
        logic reload;
    } lane_ctl_t;

    function automatic logic [WORD_W-1:0] absorb_word(
        input logic [WORD_W-1:0] lane,
        input logic [WORD_W-1:0] word
    );
        logic [WORD_W-1:0] x;
        begin
            x = lane ^ word;
            return (x << PRIME_SHIFT) + (x * PRIME_LOW);
        end
    endfunction

endpackage

`default_nettype wire

/* src/four_lane_word_hash.sv */
// ----------------------------------------------------------------------------
// four_lane_word_hash
// Frame fingerprint over a stream of 64-bit words, four lanes wide.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall): one beat carries four words, a word
// count and a last flag. A beat that is not last is always a full group and
// every lane absorbs its word in the accept cycle, so such beats stream at
// one per cycle.
// A last beat with fewer than four words folds them into lane one only,
// one word per cycle through lane one's multiplier: word one is absorbed
// on accept and any further words are folded after it. Then a merge
// combines the lanes into the output register and reloads the seeds.
// in_stall is high from the cycle after a last beat until that merge
// completes. The fingerprint shows on out_valid once the merge loads the
// output register; the merge waits while that register is still stalled.
// Output channel (out_valid / out_stall): a registered beat; while it is
// stalled the next frame's beats are still accepted, and only a new merge
// waits for the register to free up.
// Reset: lanes load their seeds, no result pending, input ready.
// ----------------------------------------------------------------------------
`default_nettype none

module four_lane_word_hash (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic [flwh_pkg::WORD_W-1:0]  word0,
    input  wire logic [flwh_pkg::WORD_W-1:0]  word1,
    input  wire logic [flwh_pkg::WORD_W-1:0]  word2,
    input  wire logic [flwh_pkg::WORD_W-1:0]  word3,
    input  wire logic [flwh_pkg::COUNT_W-1:0] word_count,
    input  wire logic                         last,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic      [flwh_pkg::WORD_W-1:0]  fingerprint
);
    import flwh_pkg::*;

    // Control sequencer: take beats, fold a short tail, merge.
    typedef enum logic [2:0] {
        ST_RUN   = 3'b001,
        ST_FOLD  = 3'b010,
        ST_MERGE = 3'b100
    } state_t;

    state_t      state_reg;
    state_t      state_next;
    logic [1:0]  remain_reg;    // tail words still to fold (1 or 2)
    logic [1:0]  remain_next;
    logic [WORD_W-1:0] hold0_reg;
    logic [WORD_W-1:0] hold1_reg;

    logic        accept;
    logic        full_group;
    logic        merge_load;
    logic        merge_free;
    lane_ctl_t   ctl [LANES];
    lane_vec_t   lanes;
    lane_vec_t   seeds;
    lane_vec_t   words;

    assign in_stall   = (state_reg != ST_RUN);
    assign accept     = in_valid && !in_stall;
    // A beat that is not last, or a count of four or more, is a full group.
    assign full_group = !last || word_count[2];
    assign merge_load = (state_reg == ST_MERGE) && merge_free;

    assign seeds[0] = SEED_ONE;
    assign seeds[1] = SEED_TWO;
    assign seeds[2] = SEED_THREE;
    assign seeds[3] = SEED_FOUR;

    // Lane one takes the tail words from the hold register while folding.
    assign words[0] = (state_reg == ST_FOLD) ? hold0_reg : word0;
    assign words[1] = word1;
    assign words[2] = word2;
    assign words[3] = word3;

    always_comb
    begin
        ctl[0].absorb = (accept && (full_group || (word_count[1:0] != 2'd0)))
                      || (state_reg == ST_FOLD);
        ctl[0].reload = merge_load;
        for (int k = 1; k < LANES; k++)
        begin
            ctl[k].absorb = accept && full_group;
            ctl[k].reload = merge_load;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        remain_next = remain_reg;
        case (state_reg)
            ST_RUN:
            begin
                if (accept && last)
                begin
                    // Word one is absorbed now; two or three words leave a tail.
                    if (!full_group && word_count[1])
                    begin
                        state_next  = ST_FOLD;
                        remain_next = word_count[1:0] - 2'd1;
                    end
                    else
                    begin
                        state_next = ST_MERGE;
                    end
                end
            end
            ST_FOLD:
            begin
                remain_next = remain_reg - 2'd1;
                if (remain_reg == 2'd1)
                begin
                    state_next = ST_MERGE;
                end
            end
            ST_MERGE:
            begin
                if (merge_load)
                begin
                    state_next = ST_RUN;
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_RUN;
            remain_reg <= 2'd0;
        end
        else
        begin
            state_reg  <= state_next;
            remain_reg <= remain_next;
        end
    end

    // Tail words shift toward lane one's input, one per fold cycle.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hold0_reg <= word1;
            hold1_reg <= word2;
        end
        else if (state_reg == ST_FOLD)
        begin
            hold0_reg <= hold1_reg;
        end
    end

    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        flwh_lane u_lane (
            .clk   (clk),
            .rst_n (rst_n),
            .ctl   (ctl[g]),
            .seed  (seeds[g]),
            .word  (words[g]),
            .lane  (lanes[g])
        );
    end

    flwh_merge u_merge (
        .clk         (clk),
        .rst_n       (rst_n),
        .lanes       (lanes),
        .load        (merge_load),
        .free        (merge_free),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .fingerprint (fingerprint)
    );

endmodule

`default_nettype wire

/* src/flwh_lane.sv */
// ----------------------------------------------------------------------------
// flwh_lane
// One hash lane: XOR a word in, multiply by the FNV-64 prime, or reload seed.
// ----------------------------------------------------------------------------
`default_nettype none

module flwh_lane (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire flwh_pkg::lane_ctl_t         ctl,
    input  wire logic [flwh_pkg::WORD_W-1:0] seed,
    input  wire logic [flwh_pkg::WORD_W-1:0] word,
    output logic      [flwh_pkg::WORD_W-1:0] lane
);
    import flwh_pkg::*;

    logic [WORD_W-1:0] lane_reg;
    logic [WORD_W-1:0] lane_next;

    always_comb
    begin
        lane_next = lane_reg;
        if (ctl.reload)
        begin
            lane_next = seed;
        end
        else if (ctl.absorb)
        begin
            lane_next = absorb_word(lane_reg, word);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lane_reg <= seed;
        end
        else
        begin
            lane_reg <= lane_next;
        end
    end

    assign lane = lane_reg;

endmodule

`default_nettype wire

/* src/flwh_merge.sv */
// ----------------------------------------------------------------------------
// flwh_merge
// Combines the four lanes into the fingerprint and holds it in the output
// register until the receiver takes the beat.
// ----------------------------------------------------------------------------
`default_nettype none

module flwh_merge (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire flwh_pkg::lane_vec_t         lanes,
    input  wire logic                        load,
    output logic                             free,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic      [flwh_pkg::WORD_W-1:0] fingerprint
);
    import flwh_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    logic [WORD_W-1:0] fp_reg;
    logic [WORD_W-1:0] fp_next;

    assign free = !valid_reg || !out_stall;

    always_comb
    begin
        fp_next = lanes[0]
                ^ (lanes[1] + MIX_ADD)
                ^ (lanes[2] << MIX_LEFT)
                ^ (lanes[3] >> MIX_RIGHT);
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (valid_reg && !out_stall)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            fp_reg <= fp_next;
        end
    end

    assign out_valid   = valid_reg;
    assign fingerprint = fp_reg;

endmodule

`default_nettype wire

/* src/flwh_checker.sv */
// ----------------------------------------------------------------------------
// flwh_checker
// Port-level checks on the four-lane word hash over time.
// ----------------------------------------------------------------------------
`default_nettype none

module flwh_checker (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    input  wire logic                         in_stall,
    input  wire logic                         last,
    input  wire logic                         out_valid,
    input  wire logic                         out_stall,
    input  wire logic [flwh_pkg::WORD_W-1:0]  fingerprint
);

    // Stalled result beat holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(fingerprint))
        else $error("result beat changed while stalled");

    // A mid-frame beat never blocks the next one.
    a_mid_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && !last |=> !in_stall)
        else $error("stall after a mid-frame beat");

    // Closing a frame raises in_stall.
    a_last_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && last |=> in_stall)
        else $error("input not held after a last beat");

    // A new result only comes out of a merge, during which input is held.
    a_result_from_merge: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result without a preceding merge");

    // No result pending while in reset.
    a_reset_clear: assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("out_valid set during reset");

endmodule

bind four_lane_word_hash flwh_checker u_flwh_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .last        (last),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .fingerprint (fingerprint)
);

`default_nettype wire
